// ===== rtl/ppl_pkg.sv =====
// Shared types and codes for the parabolic peak locator.
`timescale 1ns / 1ps

package ppl_pkg;

   // Controller states.
   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_PREP,
      ST_MUL_LOAD,
      ST_MUL_RUN,
      ST_MUL_SAVE,
      ST_COMB,
      ST_MAG,
      ST_NSUM,
      ST_CHECK,
      ST_DIV,
      ST_VERTEX,
      ST_LOAD
   } ppl_state_type;

   // Which product the shared shift-add multiplier is forming.
   typedef enum logic [1:0] {
      PROD_D1A,    // |d1| * |a|
      PROD_D2B,    // |d2| * |b|
      PROD_D1D1A,  // |d1| * |d1 * a|
      PROD_D2D2B   // |d2| * |d2 * b|
   } ppl_prod_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         track;
      logic         prep;
      logic         mul_start;
      logic         mul_step;
      logic         mul_save;
      ppl_prod_type prod;
      logic         comb;
      logic         mag;
      logic         nsum;
      logic         q_sat;
      logic         div_init;
      logic         div_step;
      logic         set_best;
      logic         set_vertex;
      logic         set_degen;
      logic         load_out;
      logic         clear;
   } ppl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic endpoint;
      logic den_zero;
      logic ovf;
   } ppl_status_type;

endpackage

// ===== rtl/ppl_dp.sv =====
// Datapath: maximum tracking, shift-add multiplier, divider and vertex saturation.
`timescale 1ns / 1ps

module ppl_dp
   import ppl_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16,
   parameter int ENERGY_WIDTH    = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ppl_cmd_type                    cmd,
   input  logic [COORD_FRAC_BITS:0]       coordinate,
   input  logic signed [ENERGY_WIDTH-1:0] energy,
   output ppl_status_type                 status,
   output logic [COORD_FRAC_BITS:0]       res_coordinate,
   output logic signed [ENERGY_WIDTH-1:0] res_energy,
   output logic                           res_endpoint,
   output logic                           res_degenerate
);

   localparam int CW  = COORD_FRAC_BITS + 1;
   localparam int EW  = ENERGY_WIDTH;
   localparam int MW  = CW + EW;        // |d| * |e|
   localparam int PW  = 2 * CW + EW;    // |d| * |d| * |e|
   localparam int NW  = PW + 2;         // signed numerator, also n = |num| + |den|
   localparam int WW  = MW + 2;         // signed denominator
   localparam int DSW = PW + 1;         // shifted divisor
   localparam logic [CW-1:0] CMAX = {1'b1, {COORD_FRAC_BITS{1'b0}}};

   // Tracking state.
   logic                 seen_ff, seen_in;
   logic                 first_ff, first_in;
   logic                 rp_ff, rp_in;
   logic signed [EW-1:0] best_e_ff, best_e_in;
   logic signed [EW-1:0] left_e_ff, left_e_in;
   logic signed [EW-1:0] right_e_ff, right_e_in;
   logic signed [EW-1:0] prev_e_ff, prev_e_in;
   logic [CW-1:0]        best_c_ff, best_c_in;
   logic [CW-1:0]        left_c_ff, left_c_in;
   logic [CW-1:0]        right_c_ff, right_c_in;
   logic [CW-1:0]        prev_c_ff, prev_c_in;

   // Differences and their magnitudes.
   logic signed [CW:0]   d1, d2;
   logic signed [EW:0]   ea, eb;
   logic [CW:0]          nd1, nd2;
   logic [EW:0]          nea, neb;
   logic [CW-1:0]        md1_ff, md2_ff;
   logic [EW-1:0]        ma_ff, mb_ff;
   logic                 sd1_ff, sd2_ff, sa_ff, sb_ff;

   // Multiplier.
   logic [PW-1:0]        mcand_ff, mcand_in;
   logic [CW-1:0]        mplier_ff, mplier_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [PW-1:0]        t1_ff, t2_ff;
   logic [MW-1:0]        t3_ff, t4_ff;

   // Combination, magnitude and division.
   logic [NW-1:0]        t1x, t2x, u_ff, nu, n_ff;
   logic [WW-1:0]        t3x, t4x, w_ff, nw;
   logic [PW:0]          mn_ff;
   logic [MW:0]          md_ff;
   logic [MW+1:0]        d2v;
   logic                 neg_ff, den_zero_ff;
   logic [NW-1:0]        r_ff, dshx;
   logic [DSW-1:0]       dsh_ff;
   logic [CW:0]          q_ff;
   logic                 div_ge;

   // Result.
   logic [CW+1:0]        vx;
   logic [CW-1:0]        sat_best, sat_vertex;
   logic [CW-1:0]        res_c_ff;
   logic                 degen_ff;

   // Maximum tracking: first strict maximum and its neighbors.
   always_comb begin
      seen_in    = seen_ff;
      first_in   = first_ff;
      rp_in      = rp_ff;
      best_e_in  = best_e_ff;
      best_c_in  = best_c_ff;
      left_e_in  = left_e_ff;
      left_c_in  = left_c_ff;
      right_e_in = right_e_ff;
      right_c_in = right_c_ff;
      prev_e_in  = prev_e_ff;
      prev_c_in  = prev_c_ff;
      if (cmd.clear) begin
         seen_in  = 1'b0;
         first_in = 1'b0;
         rp_in    = 1'b0;
      end else if (cmd.track) begin
         if (!seen_ff) begin
            best_e_in = energy;
            best_c_in = coordinate;
            first_in  = 1'b1;
            rp_in     = 1'b1;
            seen_in   = 1'b1;
         end else begin
            if (rp_ff) begin
               right_e_in = energy;
               right_c_in = coordinate;
               rp_in      = 1'b0;
            end
            if (energy > best_e_ff) begin
               left_e_in = prev_e_ff;
               left_c_in = prev_c_ff;
               best_e_in = energy;
               best_c_in = coordinate;
               first_in  = 1'b0;
               rp_in     = 1'b1;
            end
         end
         prev_e_in = energy;
         prev_c_in = coordinate;
      end
   end

   // Signed differences around the maximum.
   assign d1  = signed'({1'b0, best_c_ff}) - signed'({1'b0, left_c_ff});
   assign d2  = signed'({1'b0, right_c_ff}) - signed'({1'b0, best_c_ff});
   assign ea  = signed'({best_e_ff[EW-1], best_e_ff}) - signed'({right_e_ff[EW-1], right_e_ff});
   assign eb  = signed'({best_e_ff[EW-1], best_e_ff}) - signed'({left_e_ff[EW-1], left_e_ff});
   assign nd1 = -d1;
   assign nd2 = -d2;
   assign nea = -ea;
   assign neb = -eb;

   // Shift-add multiplier: one multiplier bit per cycle.
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (cmd.mul_start) begin
         acc_in = '0;
         unique case (cmd.prod)
            PROD_D1A: begin
               mcand_in  = PW'(ma_ff);
               mplier_in = md1_ff;
            end
            PROD_D2B: begin
               mcand_in  = PW'(mb_ff);
               mplier_in = md2_ff;
            end
            PROD_D1D1A: begin
               mcand_in  = PW'(t3_ff);
               mplier_in = md1_ff;
            end
            PROD_D2D2B: begin
               mcand_in  = PW'(t4_ff);
               mplier_in = md2_ff;
            end
            default: begin
               mcand_in  = '0;
               mplier_in = '0;
            end
         endcase
      end else if (cmd.mul_step) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[PW-2:0], 1'b0};
         mplier_in = mplier_ff >> 1;
      end
   end

   // Numerator and denominator each need only one adder, the sign is folded in later.
   assign t1x = NW'(t1_ff);
   assign t2x = NW'(t2_ff);
   assign t3x = WW'(t3_ff);
   assign t4x = WW'(t4_ff);
   assign nu  = -u_ff;
   assign nw  = -w_ff;
   assign d2v = {md_ff, 1'b0};

   // Restoring division step against the shifted divisor.
   assign dshx   = NW'(dsh_ff);
   assign div_ge = r_ff >= dshx;

   // Vertex and saturation to the unit interval.
   assign vx = neg_ff ? {2'b00, best_c_ff} + {1'b0, q_ff} : {2'b00, best_c_ff} - {1'b0, q_ff};
   always_comb begin
      sat_best = (best_c_ff > CMAX) ? CMAX : best_c_ff;
      if (vx[CW+1]) begin
         sat_vertex = '0;
      end else if (vx[CW:0] > {1'b0, CMAX}) begin
         sat_vertex = CMAX;
      end else begin
         sat_vertex = vx[CW-1:0];
      end
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         first_ff <= 1'b0;
         rp_ff    <= 1'b0;
         degen_ff <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         first_ff <= first_in;
         rp_ff    <= rp_in;
         if (cmd.clear) begin
            degen_ff <= 1'b0;
         end else if (cmd.set_degen) begin
            degen_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      best_e_ff  <= best_e_in;
      best_c_ff  <= best_c_in;
      left_e_ff  <= left_e_in;
      left_c_ff  <= left_c_in;
      right_e_ff <= right_e_in;
      right_c_ff <= right_c_in;
      prev_e_ff  <= prev_e_in;
      prev_c_ff  <= prev_c_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      acc_ff     <= acc_in;
      if (cmd.prep) begin
         md1_ff <= d1[CW] ? nd1[CW-1:0] : d1[CW-1:0];
         md2_ff <= d2[CW] ? nd2[CW-1:0] : d2[CW-1:0];
         ma_ff  <= ea[EW] ? nea[EW-1:0] : ea[EW-1:0];
         mb_ff  <= eb[EW] ? neb[EW-1:0] : eb[EW-1:0];
         sd1_ff <= d1[CW];
         sd2_ff <= d2[CW];
         sa_ff  <= ea[EW];
         sb_ff  <= eb[EW];
      end
      if (cmd.mul_save) begin
         unique case (cmd.prod)
            PROD_D1A:   t3_ff <= acc_ff[MW-1:0];
            PROD_D2B:   t4_ff <= acc_ff[MW-1:0];
            PROD_D1D1A: t1_ff <= acc_ff;
            PROD_D2D2B: t2_ff <= acc_ff;
            default:    t1_ff <= acc_ff;
         endcase
      end
      if (cmd.comb) begin
         u_ff <= (sa_ff == sb_ff) ? t1x - t2x : t1x + t2x;
         w_ff <= ((sa_ff ^ sd1_ff) == (sb_ff ^ sd2_ff)) ? t3x + t4x : t3x - t4x;
      end
      if (cmd.mag) begin
         mn_ff       <= u_ff[NW-1] ? nu[PW:0] : u_ff[PW:0];
         md_ff       <= w_ff[WW-1] ? nw[MW:0] : w_ff[MW:0];
         neg_ff      <= sa_ff ^ u_ff[NW-1] ^ sa_ff ^ sd1_ff ^ w_ff[WW-1];
         den_zero_ff <= (w_ff == '0);
      end
      if (cmd.nsum) begin
         n_ff <= NW'(mn_ff) + NW'(md_ff);
      end
      if (cmd.q_sat) begin
         q_ff <= {1'b1, {CW{1'b0}}};
      end else if (cmd.div_init) begin
         r_ff   <= n_ff;
         dsh_ff <= {d2v, {(CW - 1){1'b0}}};
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         r_ff   <= div_ge ? r_ff - dshx : r_ff;
         dsh_ff <= dsh_ff >> 1;
         q_ff   <= {q_ff[CW-1:0], div_ge};
      end
      if (cmd.set_best) begin
         res_c_ff <= sat_best;
      end else if (cmd.set_vertex) begin
         res_c_ff <= sat_vertex;
      end
   end

   // Status and result.
   assign status.endpoint = first_ff | rp_ff;
   assign status.den_zero = den_zero_ff;
   assign status.ovf      = n_ff >= {d2v, {CW{1'b0}}};
   assign res_coordinate  = res_c_ff;
   assign res_energy      = best_e_ff;
   assign res_endpoint    = first_ff | rp_ff;
   assign res_degenerate  = degen_ff;

   // The divider only runs on an in-range quotient with a nonzero divisor.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> !den_zero_ff && !status.ovf)
      else $error("divider started on zero divisor or overflowing quotient");

   // A degenerate result never comes from an endpoint profile.
   assert property (@(posedge clock) disable iff (reset)
      cmd.set_degen |-> !(first_ff | rp_ff))
      else $error("degenerate flag raised on an endpoint profile");

   // Tracking only runs between results.
   assert property (@(posedge clock) disable iff (reset)
      cmd.track |-> !cmd.clear)
      else $error("sample tracked while state is cleared");

endmodule

// ===== rtl/ppl_ctrl.sv =====
// Controller: sequences tracking, the four products, division and result hand-off.
`timescale 1ns / 1ps

module ppl_ctrl
   import ppl_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tlast,
   input  logic           out_free,
   input  ppl_status_type status,
   output logic           req_tready,
   output ppl_cmd_type    cmd
);

   localparam int CW    = COORD_FRAC_BITS + 1;
   localparam int CNT_W = $clog2(CW);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CW - 1);

   ppl_state_type    state_ff, state_in;
   ppl_prod_type     prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Next state, step counter and product selector.
   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.endpoint) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_MUL_LOAD;
               prod_in  = PROD_D1A;
            end
         end
         ST_MUL_LOAD: begin
            state_in = ST_MUL_RUN;
            cnt_in   = '0;
         end
         ST_MUL_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_MUL_SAVE;
            end
         end
         ST_MUL_SAVE: begin
            unique case (prod_ff)
               PROD_D1A: begin
                  prod_in  = PROD_D2B;
                  state_in = ST_MUL_LOAD;
               end
               PROD_D2B: begin
                  prod_in  = PROD_D1D1A;
                  state_in = ST_MUL_LOAD;
               end
               PROD_D1D1A: begin
                  prod_in  = PROD_D2D2B;
                  state_in = ST_MUL_LOAD;
               end
               PROD_D2D2B: state_in = ST_COMB;
               default:    state_in = ST_COMB;
            endcase
         end
         ST_COMB:   state_in = ST_MAG;
         ST_MAG:    state_in = ST_NSUM;
         ST_NSUM:   state_in = ST_CHECK;
         ST_CHECK: begin
            priority if (status.den_zero) begin
               state_in = ST_LOAD;
            end else if (status.ovf) begin
               state_in = ST_VERTEX;
            end else begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_VERTEX;
            end
         end
         ST_VERTEX: state_in = ST_LOAD;
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // Commands for the current state.
   always_comb begin
      cmd        = '0;
      cmd.prod   = prod_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            cmd.track  = req_tvalid;
         end
         ST_PREP: begin
            cmd.prep     = 1'b1;
            cmd.set_best = status.endpoint;
         end
         ST_MUL_LOAD: cmd.mul_start = 1'b1;
         ST_MUL_RUN:  cmd.mul_step  = 1'b1;
         ST_MUL_SAVE: cmd.mul_save  = 1'b1;
         ST_COMB:     cmd.comb      = 1'b1;
         ST_MAG:      cmd.mag       = 1'b1;
         ST_NSUM:     cmd.nsum      = 1'b1;
         ST_CHECK: begin
            priority if (status.den_zero) begin
               cmd.set_best  = 1'b1;
               cmd.set_degen = 1'b1;
            end else if (status.ovf) begin
               cmd.q_sat = 1'b1;
            end else begin
               cmd.div_init = 1'b1;
            end
         end
         ST_DIV:    cmd.div_step   = 1'b1;
         ST_VERTEX: cmd.set_vertex = 1'b1;
         ST_LOAD: begin
            cmd.load_out = out_free;
            cmd.clear    = out_free;
         end
         default: cmd = '0;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         prod_ff  <= PROD_D1A;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         prod_ff  <= prod_in;
         cnt_ff   <= cnt_in;
      end
   end

   // A result is only handed over when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result loaded over an untaken word");

   // The last sample of a profile starts the finishing sequence.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.track && req_tlast) |=> state_ff == ST_PREP)
      else $error("last sample did not start the vertex computation");

   // The divider is never started on a zero denominator.
   assert property (@(posedge clock) disable iff (reset)
      cmd.set_degen |-> !cmd.div_init && status.den_zero)
      else $error("degenerate result without a zero denominator");

endmodule

// ===== rtl/parabolic_peak_locator.sv =====
// Top level of the parabolic peak locator: ports, controller, datapath, output register.
//
// Samples arrive on the req_ stream, one word per (coordinate, energy) pair, with
// req_tlast on the final sample of a profile. Every word of a profile is taken as soon
// as it is offered. The block keeps the first strict maximum and its two neighbors.
// After the last sample it emits one word on the rsp_ stream: the peak coordinate
// (the parabola vertex, or the maximum sample at an endpoint or on a zero
// denominator), the maximum energy, and the endpoint and degenerate flags in tuser.
// An endpoint profile goes from the last sample through the prep and load states. An
// interior peak also runs the shift-add multiplier (four products, one bit a cycle)
// and the restoring divider (one quotient bit a cycle); a quotient that overflows
// skips the divider.
// req_tready is low from the last sample until the result is in the output
// register. A stalled rsp_ side holds the word and the next profile may be
// streamed in meanwhile; its result waits until the word is taken.
// Reset is synchronous and clears the controller state, the tracking flags and any pending result.
`timescale 1ns / 1ps

module parabolic_peak_locator
   import ppl_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16,
   parameter int ENERGY_WIDTH    = 32,
   localparam int CW      = COORD_FRAC_BITS + 1,
   localparam int TDATA_W = ((CW + ENERGY_WIDTH + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // coordinate, energy, zero fill
   input  logic               req_tlast,   // last_sample
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // peak_coordinate, peak_energy, zero fill
   output logic [1:0]         rsp_tuser    // at_endpoint, degenerate
);

   localparam int EW = ENERGY_WIDTH;

   ppl_cmd_type          cmd;
   ppl_status_type       status;
   logic                 out_free;
   logic [CW-1:0]        res_coordinate;
   logic signed [EW-1:0] res_energy;
   logic                 res_endpoint, res_degenerate;

   logic                 rsp_valid_ff;
   logic [CW-1:0]        rsp_coord_ff;
   logic [EW-1:0]        rsp_energy_ff;
   logic                 rsp_endpoint_ff, rsp_degen_ff;

   ppl_ctrl #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   ppl_dp #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .ENERGY_WIDTH   (ENERGY_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .coordinate     (req_tdata[CW-1:0]),
      .energy         (signed'(req_tdata[CW+EW-1:CW])),
      .status         (status),
      .res_coordinate (res_coordinate),
      .res_energy     (res_energy),
      .res_endpoint   (res_endpoint),
      .res_degenerate (res_degenerate)
   );

   // Output register: free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_coord_ff    <= res_coordinate;
         rsp_energy_ff   <= res_energy;
         rsp_endpoint_ff <= res_endpoint;
         rsp_degen_ff    <= res_degenerate;
      end
   end

   // Pack the result word.
   always_comb begin
      rsp_tdata             = '0;
      rsp_tdata[CW-1:0]     = rsp_coord_ff;
      rsp_tdata[CW+EW-1:CW] = rsp_energy_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_degen_ff, rsp_endpoint_ff};

endmodule

// ===== dv/tb_parabolic_peak_locator.sv =====
// Self-checking testbench for the parabolic peak locator: directed profiles, then random ones.
`timescale 1ns / 1ps

module tb_parabolic_peak_locator;

   localparam int     COORD_BITS      = 17;
   localparam int     ENERGY_BITS     = 32;
   localparam int     TDATA_BITS      = 56;
   localparam int     FILL_BITS       = TDATA_BITS - COORD_BITS - ENERGY_BITS;
   localparam int     USER_ENDPOINT   = 0;
   localparam int     USER_DEGENERATE = 1;
   localparam longint COORD_MAX       = 64'sd65536;
   localparam longint ENERGY_MIN      = -64'sd2147483648;
   localparam int     RANDOM_ITEMS    = 1875;
   localparam int     HOLD_CYCLES     = 300;
   localparam int     DRAIN_CYCLES    = 200;
   localparam longint TIMEOUT_NS      = 64'd8_000_000;

   // One result word as the block reports it.
   typedef struct packed {
      logic [COORD_BITS-1:0]         coord;
      logic signed [ENERGY_BITS-1:0] energy;
      logic                          at_endpoint;
      logic                          degenerate;
   } peak_word_type;

   // One directed sample; the expected word is typed in only where typed is set.
   typedef struct packed {
      logic [COORD_BITS-1:0]         coord;
      logic signed [ENERGY_BITS-1:0] energy;
      logic                          last;
      logic                          typed;
      peak_word_type                 want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_BITS-1:0] req_tdata = '0;   // coordinate, energy, zero fill
   logic                  req_tlast = 1'b0; // last_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_BITS-1:0] rsp_tdata;        // peak_coordinate, peak_energy, zero fill
   logic [1:0]            rsp_tuser;        // at_endpoint, degenerate

   // Peak tracker state, mirrored from the block's behavior.
   logic [COORD_BITS-1:0]         top_c = '0, before_c = '0, after_c = '0, last_c = '0;
   logic signed [ENERGY_BITS-1:0] top_e = '0, before_e = '0, after_e = '0, last_e = '0;
   bit                            in_profile = 1'b0, top_is_first = 1'b0, after_open = 1'b0;

   peak_word_type                 expected_peaks[$];
   logic [COORD_BITS-1:0]         prof_coord[$];
   logic signed [ENERGY_BITS-1:0] prof_energy[$];
   int                            error_count = 0;
   int                            send_idle_pct = 6;
   int                            rsp_idle_pct = 61;
   bit                            hold_request = 1'b0;

   // Directed profiles: extremes, endpoints, ties, zero denominator and saturation.
   stim_row_type directed_rows [0:24] = '{
      // single sample right after reset, largest energy
      '{17'h00000, 32'sh7FFFFFFF, 1'b1, 1'b1, '{17'h00000, 32'sh7FFFFFFF, 1'b1, 1'b0}},
      // single sample, coordinate above 1.0, smallest energy
      '{17'h1FFFF, 32'sh80000000, 1'b1, 1'b1, '{17'h10000, 32'sh80000000, 1'b1, 1'b0}},
      // tie with the first sample keeps the first one
      '{17'd10, 32'sd5, 1'b0, 1'b0, '0},
      '{17'd20, 32'sd5, 1'b0, 1'b0, '0},
      '{17'd30, 32'sd2, 1'b1, 1'b1, '{17'd10, 32'sd5, 1'b1, 1'b0}},
      // maximum on the last sample
      '{17'd100, -32'sd5, 1'b0, 1'b0, '0},
      '{17'd200, 32'sd0, 1'b0, 1'b0, '0},
      '{17'd300, 32'sd7, 1'b1, 1'b1, '{17'd300, 32'sd7, 1'b1, 1'b0}},
      // all coordinates equal, so the denominator is zero
      '{17'h00100, 32'sd0, 1'b0, 1'b0, '0},
      '{17'h00100, 32'sd5, 1'b0, 1'b0, '0},
      '{17'h00100, 32'sd0, 1'b1, 1'b1, '{17'h00100, 32'sd5, 1'b0, 1'b1}},
      // vertex below zero
      '{17'd0, 32'sd81, 1'b0, 1'b0, '0},
      '{17'd2, 32'sd100, 1'b0, 1'b0, '0},
      '{17'd1, 32'sd90, 1'b1, 1'b1, '{17'd0, 32'sd100, 1'b0, 1'b0}},
      // vertex above 1.0
      '{17'h10000, 32'sd81, 1'b0, 1'b0, '0},
      '{17'h0FFFE, 32'sd100, 1'b0, 1'b0, '0},
      '{17'h0FFFF, 32'sd90, 1'b1, 1'b1, '{17'h10000, 32'sd100, 1'b0, 1'b0}},
      // tiny denominator, the quotient overflows
      '{17'h00000, 32'sh8000FFFE, 1'b0, 1'b0, '0},
      '{17'h10000, 32'sh7FFFFFFF, 1'b0, 1'b0, '0},
      '{17'h00001, 32'sh8001FFFD, 1'b1, 1'b0, '0},
      // the maximum moves several times before settling inside
      '{17'd0, -32'sd10, 1'b0, 1'b0, '0},
      '{17'd10, 32'sd3, 1'b0, 1'b0, '0},
      '{17'd20, 32'sd1, 1'b0, 1'b0, '0},
      '{17'd30, 32'sd8, 1'b0, 1'b0, '0},
      '{17'd40, 32'sd2, 1'b1, 1'b0, '0}
   };

   parabolic_peak_locator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prints one line per problem and counts it.
   task automatic flag_error(input string msg);
      error_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   // Advances the peak tracker by one sample; returns 1 with the peak word on the last sample.
   function automatic bit track_sample(input logic [COORD_BITS-1:0] c,
                                       input logic signed [ENERGY_BITS-1:0] e,
                                       input logic last, output peak_word_type res);
      logic signed [127:0] ct, cl, cr, wt, wl, wr, wd1, wd2, wa, wb, num, den;
      logic [127:0]        mag_n, mag_d, quo;
      longint              off, x;
      bit                  neg;

      // Keep the first strict maximum and the samples on either side of it.
      if (!in_profile) begin
         top_c = c;
         top_e = e;
         top_is_first = 1'b1;
         after_open = 1'b1;
         in_profile = 1'b1;
      end else begin
         if (after_open) begin
            after_c = c;
            after_e = e;
            after_open = 1'b0;
         end
         if (e > top_e) begin
            before_c = last_c;
            before_e = last_e;
            top_c = c;
            top_e = e;
            top_is_first = 1'b0;
            after_open = 1'b1;
         end
      end
      last_c = c;
      last_e = e;
      if (!last)
         return 1'b0;

      res = '0;
      res.energy = top_e;
      res.at_endpoint = top_is_first || after_open;
      x = longint'(top_c);
      if (!res.at_endpoint) begin
         // Closed-form vertex, exact in 128 bits.
         ct = 128'(top_c);
         cl = 128'(before_c);
         cr = 128'(after_c);
         wt = 128'(top_e);
         wl = 128'(before_e);
         wr = 128'(after_e);
         wd1 = ct - cl;
         wd2 = cr - ct;
         wa = wt - wr;
         wb = wt - wl;
         num = wd1 * wd1 * wa - wd2 * wd2 * wb;
         den = wd1 * wa + wd2 * wb;
         if (den == 0) begin
            res.degenerate = 1'b1;
         end else begin
            // Offset magnitude rounded half away from zero, capped at 2^40.
            neg = num[127] != den[127];
            mag_n = num[127] ? -num : num;
            mag_d = den[127] ? -den : den;
            quo = (mag_n + mag_d) / (mag_d << 1);
            if (quo > (128'd1 << 40))
               quo = 128'd1 << 40;
            off = longint'(quo[40:0]);
            x = neg ? x + off : x - off;
         end
      end
      res.coord = (x < 0) ? '0 : (x > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(x);

      // A result ends the profile.
      top_c = '0;
      top_e = '0;
      before_c = '0;
      before_e = '0;
      after_c = '0;
      after_e = '0;
      last_c = '0;
      last_e = '0;
      in_profile = 1'b0;
      top_is_first = 1'b0;
      after_open = 1'b0;
      return 1'b1;
   endfunction

   // Offers one sample word from a falling edge and returns at the falling edge after it is taken.
   task automatic push_sample(input logic [COORD_BITS-1:0] coord,
                              input logic signed [ENERGY_BITS-1:0] energy,
                              input logic last, input logic typed, input peak_word_type want);
      peak_word_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{FILL_BITS{1'b0}}, energy, coord};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (track_sample(coord, energy, last, predicted))
         expected_peaks.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Fills the profile queues with one random profile.
   task automatic build_profile();
      int          kind, count, top, step, span, gap, i;
      int          rnd;
      longint      base, e;
      logic [16:0] c;
      prof_coord.delete();
      prof_energy.delete();
      kind = $urandom_range(99);
      if (kind < 65) begin
         // Well-formed: rising coordinates, one hump of energy at a random place.
         count = $urandom_range(12, 3);
         top = $urandom_range(count - 1);
         step = $urandom_range(65536 / count, 1);
         c = COORD_BITS'($urandom_range(65536 - step * (count - 1)));
         rnd = $urandom;
         base = rnd;
         span = $urandom_range(1) ? $urandom_range(64, 1) : $urandom_range(1 << 24, 1);
         for (i = 0; i < count; i++) begin
            gap = (i > top) ? i - top : top - i;
            e = base - longint'(gap) * longint'($urandom_range(span, 0));
            if (e < ENERGY_MIN)
               e = ENERGY_MIN;
            prof_coord.push_back(c + COORD_BITS'(i * step));
            prof_energy.push_back(e[31:0]);
         end
      end else if (kind < 85) begin
         // Noise: any coordinate, any energy.
         count = $urandom_range(6, 1);
         for (i = 0; i < count; i++) begin
            prof_coord.push_back(COORD_BITS'($urandom_range(17'h1FFFF)));
            prof_energy.push_back($urandom_range(1) ? $urandom : $urandom_range(6) - 3);
         end
      end else if (kind < 95) begin
         // Repeated coordinate, small energies.
         count = $urandom_range(5, 3);
         c = COORD_BITS'($urandom_range(17'h1FFFF));
         for (i = 0; i < count; i++) begin
            prof_coord.push_back(c);
            prof_energy.push_back($urandom_range(20) - 10);
         end
      end else begin
         // Long random walk.
         count = $urandom_range(40, 20);
         c = COORD_BITS'($urandom_range(50000));
         e = longint'($urandom_range(1 << 20)) - (1 << 19);
         for (i = 0; i < count; i++) begin
            c = c + COORD_BITS'($urandom_range(200));
            e = e + longint'($urandom_range(200)) - 100;
            prof_coord.push_back(c);
            prof_energy.push_back(e[31:0]);
         end
      end
   endtask

   // Compares a result word with the oldest expectation.
   task automatic check_peak();
      peak_word_type want;
      if (expected_peaks.size() == 0) begin
         flag_error($sformatf("result word with nothing expected: tdata %h tuser %b",
                              rsp_tdata, rsp_tuser));
         return;
      end
      want = expected_peaks.pop_front();
      if (rsp_tdata[COORD_BITS-1:0] !== want.coord)
         flag_error($sformatf("peak_coordinate %h, expected %h",
                              rsp_tdata[COORD_BITS-1:0], want.coord));
      if (rsp_tdata[COORD_BITS +: ENERGY_BITS] !== want.energy)
         flag_error($sformatf("peak_energy %h, expected %h",
                              rsp_tdata[COORD_BITS +: ENERGY_BITS], want.energy));
      if (rsp_tuser[USER_ENDPOINT] !== want.at_endpoint)
         flag_error($sformatf("at_endpoint %b, expected %b",
                              rsp_tuser[USER_ENDPOINT], want.at_endpoint));
      if (rsp_tuser[USER_DEGENERATE] !== want.degenerate)
         flag_error($sformatf("degenerate %b, expected %b",
                              rsp_tuser[USER_DEGENERATE], want.degenerate));
   endtask

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin : rsp_side
      int hold_left;
      bit ready_next;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = ($urandom_range(99) >= rsp_idle_pct);
         end
         @(negedge clock);
         rsp_tready <= ready_next;
      end
   end

   // Every word taken from the block is checked.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_peak();
   end

   // Stimulus and end of run.
   initial begin : req_side
      int sent, phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r])
         push_sample(directed_rows[r].coord, directed_rows[r].energy, directed_rows[r].last,
                     directed_rows[r].typed, directed_rows[r].want);

      // Random profiles in three idling phases; the last one opens with a long hold-off.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0 && sent >= RANDOM_ITEMS / 3) begin
            phase = 1;
            send_idle_pct = 61;
            rsp_idle_pct = 6;
         end else if (phase == 1 && sent >= 2 * RANDOM_ITEMS / 3) begin
            phase = 2;
            send_idle_pct = 0;
            rsp_idle_pct = 0;
            hold_request = 1'b1;
         end
         build_profile();
         foreach (prof_coord[i])
            push_sample(prof_coord[i], prof_energy[i], i == prof_coord.size() - 1, 1'b0, '0);
         sent += prof_coord.size();
      end
      req_tvalid <= 1'b0;

      while (expected_peaks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog.
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", expected_peaks.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ppl_pkg.sv
rtl/ppl_dp.sv
rtl/ppl_ctrl.sv
rtl/parabolic_peak_locator.sv
dv/tb_parabolic_peak_locator.sv
